>>> hw/rtl/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants of the k-th largest selector
// Widths, depth of the ranked cell chain and the link and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  // Number of ranked cells and the width of one value.
  localparam int K_MAX      = 16;
  localparam int DATA_WIDTH = 32;

  // Index into the cell chain.
  localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // Rank register and saturating item counter.
  localparam int RANK_W  = 5;
  localparam int COUNT_W = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [RANK_W-1:0]  RANK_RESET = RANK_W'(1);

  // Most negative value, reported when the answer is invalid.
  localparam logic [DATA_WIDTH-1:0] VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // What one cell hands to the next one down the chain.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;  // held value
    logic                  occ;    // cell holds a value
    logic                  ins;    // new sample belongs at or above this cell
  } cell_link_t;

  // One result beat.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] kth_value;
    logic                  answer_valid;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/kls_ifs.sv
// ----------------------------------------------------------------------------
// kls_ifs: channel interfaces of the k-th largest selector
// Sample input channel, result output channel and rank write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface kls_in_if;
  logic                           valid;
  logic                           ready;
  logic [kls_pkg::DATA_WIDTH-1:0] sample_value;
  logic                           end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface kls_out_if;
  logic                           valid;
  logic                           ready;
  logic [kls_pkg::DATA_WIDTH-1:0] kth_value;
  logic                           answer_valid;

  modport source (output valid, output kth_value, output answer_valid, input ready);
  modport sink   (input valid, input kth_value, input answer_valid, output ready);
endinterface

interface kls_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kls_pkg::RANK_W-1:0] rank_k;

  modport source (output valid, output rank_k, input ready);
  modport sink   (input valid, input rank_k, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kth_largest_selector.sv
// ----------------------------------------------------------------------------
// kth_largest_selector: k-th largest value of a streamed set
// Sorted insertion chain of ranked cells, item counter and result skid stage.
// ----------------------------------------------------------------------------
// Usage. Samples arrive as beats on the samples channel, one signed value per
// beat; the last beat of a set has end_of_set high. Each beat is taken into a
// chain of K_MAX cells that keeps the largest values of the set in descending
// order, duplicates included. Every cell compares the sample with its own
// value in the same cycle and either keeps, takes the sample, or takes its
// upper neighbour's value, so a new beat may be accepted every cycle while
// the result skid stage is not full.
// On the end-of-set beat the chain's post-insertion content is read at rank
// rank_k and the result beat is written to the output register, or to the
// skid stage while that register is held. The cells and the item count
// then clear for the next set. A rank of zero, beyond the set size or beyond
// K_MAX yields answer_valid low and the most negative value.
// The result side has an output register and a skid stage: if the receiver
// stalls, one further result is held and samples are only refused once both
// are full. rank_k is written through the cfg channel, which is always ready;
// it should be written between sets. Reset (rst, synchronous) empties the
// chain, clears the count and sets rank_k to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_largest_selector (
  input  wire logic  clk,
  input  wire logic  rst,
  kls_in_if.sink     samples,
  kls_cfg_if.sink    cfg,
  kls_out_if.source  result
);

  logic [kls_pkg::RANK_W-1:0]     rank_k;
  logic [kls_pkg::COUNT_W-1:0]    seen_count;
  logic [kls_pkg::COUNT_W-1:0]    seen_count_next;
  logic                           accept;
  logic                           last_beat;
  logic                           has_room;
  logic                           answer_ok;
  logic [kls_pkg::IDX_W-1:0]      pick;
  logic [kls_pkg::RANK_W-1:0]     rank_m1;
  logic [kls_pkg::K_MAX-1:0]      occ_vec;
  kls_pkg::result_t               answer;

  kls_pkg::cell_link_t            links [kls_pkg::K_MAX+1];
  logic [kls_pkg::DATA_WIDTH-1:0] cell_next [kls_pkg::K_MAX];

  assign samples.ready = has_room;
  assign accept        = samples.valid && has_room;
  assign last_beat     = accept && samples.end_of_set;

  // The rank register can be written at any time.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= kls_pkg::RANK_RESET;
    end else if (cfg.valid) begin
      rank_k <= cfg.rank_k;
    end
  end

  // Top of the chain: nothing is ever shifted into the first cell.
  assign links[0] = '0;

  for (genvar i = 0; i < kls_pkg::K_MAX; i++) begin : g_cell
    kls_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .take       (accept),
      .clear      (last_beat),
      .sample     (samples.sample_value),
      .prev       (links[i]),
      .link       (links[i+1]),
      .value_next (cell_next[i])
    );
  end

  always_comb begin
    for (int i = 0; i < kls_pkg::K_MAX; i++) begin
      occ_vec[i] = links[i+1].occ;
    end
  end

  // Item count including the current beat, saturating at its maximum.
  assign seen_count_next = (seen_count == kls_pkg::COUNT_MAX) ?
                           seen_count : seen_count + kls_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      seen_count <= samples.end_of_set ? '0 : seen_count_next;
    end
  end

  // The answer reads the chain as it stands after this beat is inserted.
  assign answer_ok = (rank_k != '0) &&
                     (32'(rank_k) <= 32'(seen_count_next)) &&
                     (32'(rank_k) <= 32'(kls_pkg::K_MAX));
  assign rank_m1   = rank_k - kls_pkg::RANK_W'(1);
  assign pick      = kls_pkg::IDX_W'(rank_m1);

  always_comb begin
    answer.answer_valid = answer_ok;
    answer.kth_value    = answer_ok ? cell_next[pick] : kls_pkg::VALUE_MIN;
  end

  kls_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (last_beat),
    .push_data (answer),
    .has_room  (has_room),
    .result    (result)
  );

  // Occupied cells always form an unbroken run from the top of the chain.
  a_occ_prefix : assert property (@(posedge clk) disable iff (rst)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("ranked cells occupied with a gap");

  // A beat that is not the last of its set advances the count by one.
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    accept && !samples.end_of_set && (seen_count != kls_pkg::COUNT_MAX)
    |=> seen_count == $past(seen_count) + kls_pkg::COUNT_W'(1))
    else $error("item count did not advance");

  // After the last beat of a set the chain and the count are empty.
  a_set_clear : assert property (@(posedge clk) disable iff (rst)
    last_beat |=> (seen_count == '0) && (occ_vec == '0))
    else $error("state not cleared after end of set");

  // A result is only ever produced when the skid stage has room for it.
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    last_beat |-> has_room)
    else $error("result pushed into a full output stage");

endmodule

`default_nettype wire

>>> hw/rtl/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell: one ranked cell of the insertion chain
// Holds one value; takes the new sample, its upper neighbour's value or keeps.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           take,
  input  wire logic                           clear,
  input  wire logic [kls_pkg::DATA_WIDTH-1:0] sample,
  input  wire kls_pkg::cell_link_t            prev,
  output kls_pkg::cell_link_t                 link,
  output logic [kls_pkg::DATA_WIDTH-1:0]      value_next
);

  logic [kls_pkg::DATA_WIDTH-1:0] value;
  logic                           occ;
  logic                           occ_next;
  logic                           ins;

  // The sample goes here or above when this cell is empty or smaller.
  assign ins = !occ || ($signed(sample) > $signed(value));

  always_comb begin
    if (prev.ins) begin
      value_next = prev.value;
      occ_next   = prev.occ;
    end else if (ins) begin
      value_next = sample;
      occ_next   = 1'b1;
    end else begin
      value_next = value;
      occ_next   = occ;
    end
  end

  assign link = '{value: value, occ: occ, ins: ins};

  always_ff @(posedge clk) begin
    if (take) begin
      value <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (take) begin
      occ <= clear ? 1'b0 : occ_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kls_out_skid.sv
// ----------------------------------------------------------------------------
// kls_out_skid: output register with skid stage
// Holds result beats so that a stalled receiver never loses one.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_out_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire kls_pkg::result_t  push_data,
  output logic                   has_room,
  kls_out_if.source              result
);

  kls_pkg::result_t main_data;
  kls_pkg::result_t skid_data;
  logic             main_valid;
  logic             skid_valid;
  logic             pop;

  assign pop      = main_valid && result.ready;
  assign has_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  assign result.valid        = main_valid;
  assign result.kth_value    = main_data.kth_value;
  assign result.answer_valid = main_data.answer_valid;

endmodule

`default_nettype wire

>>> tb/sv/kls_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kls_result_checker: scoreboard for the k-th largest selector
// Watches the sample, rank and result channels. It keeps its own ranked copy
// of the current set and compares each result beat with the oldest answer owed.
// ----------------------------------------------------------------------------

module kls_result_checker (
  input  logic clk,
  input  logic rst,
  kls_in_if    samples,
  kls_cfg_if   cfg,
  kls_out_if   result,
  output int   fail_count,
  output int   pending
);
  import kls_pkg::*;

  // The largest values of the current set, largest first, with their count.
  logic signed [DATA_WIDTH-1:0] kept [K_MAX];
  logic [COUNT_W-1:0]           set_items;
  logic [RANK_W-1:0]            rank_sel;
  result_t                      owed_answers [$];

  // Sorted insertion. When every cell is full, only a value strictly greater
  // than the smallest kept one gets in, and the smallest one drops out.
  task automatic absorb_sample(input logic signed [DATA_WIDTH-1:0] v);
    int held;
    int pos;
    int i;
    held = (set_items < K_MAX) ? int'(set_items) : K_MAX;
    pos  = 0;
    while (pos < held && kept[pos] >= v) pos++;
    if (pos < K_MAX) begin
      i = (held < K_MAX) ? held : K_MAX - 1;
      while (i > pos) begin
        kept[i] = kept[i-1];
        i--;
      end
      kept[pos] = v;
    end
  endtask

  function automatic result_t rank_answer();
    result_t a;
    if (rank_sel != 0 && rank_sel <= set_items && rank_sel <= K_MAX) begin
      a.kth_value    = kept[rank_sel - 1'b1];
      a.answer_valid = 1'b1;
    end else begin
      a.kth_value    = VALUE_MIN;
      a.answer_valid = 1'b0;
    end
    return a;
  endfunction

  task automatic note_failure(input string what, input logic [DATA_WIDTH-1:0] want_v,
                              input logic [DATA_WIDTH-1:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s differs: expected %0d, got %0d", $time, what,
               $signed(want_v), $signed(got_v));
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      set_items = '0;
      rank_sel  = RANK_RESET;
      owed_answers.delete();
    end else begin
      // The result beat is handled first: it can only belong to an earlier set.
      if (result.valid && result.ready) begin
        got.kth_value    = result.kth_value;
        got.answer_valid = result.answer_valid;
        if (owed_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with no answer owed: kth_value %0d, answer_valid %0b",
                     $time, $signed(got.kth_value), got.answer_valid);
        end else begin
          want = owed_answers.pop_front();
          if (got.kth_value !== want.kth_value)
            note_failure("kth_value", want.kth_value, got.kth_value);
          if (got.answer_valid !== want.answer_valid)
            note_failure("answer_valid", DATA_WIDTH'(want.answer_valid),
                         DATA_WIDTH'(got.answer_valid));
        end
      end
      if (cfg.valid && cfg.ready) rank_sel = cfg.rank_k;
      if (samples.valid && samples.ready) begin
        absorb_sample(samples.sample_value);
        if (set_items != COUNT_MAX) set_items++;
        if (samples.end_of_set) begin
          owed_answers.push_back(rank_answer());
          set_items = '0;
        end
      end
    end
    pending = owed_answers.size();
  end

endmodule

>>> tb/sv/tb_kth_largest_selector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kth_largest_selector: stimulus and verdict for the k-th largest selector
// Streams directed and random sets of signed values under several ranks, with
// random idling on both channels; a checker beside the block scores results.
// ----------------------------------------------------------------------------

module tb_kth_largest_selector;
  import kls_pkg::*;

  // Cycles to let pass after the last owed answer before the rank is touched.
  localparam int SETTLE_CYCLES = 4;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LONG_HOLD     = 300;
  // Items per random phase; ten phases give roughly the wanted total.
  localparam int PHASE_ITEMS   = 195;
  localparam int PHASES        = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  kls_in_if  samp_if ();
  kls_out_if res_if ();
  kls_cfg_if cfg_if ();

  kth_largest_selector uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_if),
    .cfg     (cfg_if),
    .result  (res_if)
  );

  int fail_count;
  int pending;

  kls_result_checker kls_watch (
    .clk        (clk),
    .rst        (rst),
    .samples    (samp_if),
    .cfg        (cfg_if),
    .result     (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Shared between the sender and the receiver. idle_odds gives the chance
  // (one in idle_odds per beat) that an idle burst starts; zero means none.
  // calm switches all idling off for the last part of the run. The sender asks
  // for the long hold-off by bumping hold_asks; the receiver answers it.
  int idle_odds = 0;
  bit calm      = 1'b0;
  int hold_asks = 0;
  int hold_done = 0;

  // Safety net: far beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver. Exactly one assignment to ready at each falling edge: either a
  // stall cycle from a burst under way, or ready high.
  initial begin : drain
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        hold_done++;
        stall = LONG_HOLD;
      end else if (stall == 0 && !calm && idle_odds != 0 &&
                   $urandom_range(1, idle_odds) == 1) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Offers one sample beat and returns at the falling edge after it has been
  // taken, with valid still high so that the next beat can follow at once.
  task automatic send_sample(input logic [DATA_WIDTH-1:0] v, input logic last);
    int gap;
    if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 11);
      samp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samp_if.valid        <= 1'b1;
    samp_if.sample_value <= v;
    samp_if.end_of_set   <= last;
    @(posedge clk);
    while (!samp_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drops valid and waits until every owed answer has come back, then a few
  // cycles more, so that the block is idle before the rank is rewritten.
  task automatic settle();
    samp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] r);
    cfg_if.rank_k <= r;
    cfg_if.valid  <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Values come in three flavours: the full 32-bit range, the extremes and
  // their neighbours, and a narrow band around zero that gives many duplicates.
  function automatic logic [DATA_WIDTH-1:0] pick_value(input int flavour);
    logic [DATA_WIDTH-1:0] edges [8];
    edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
              32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_AAAA};
    case (flavour)
      0:       return edges[$urandom_range(0, 7)];
      1:       return DATA_WIDTH'($urandom_range(0, 8)) - DATA_WIDTH'(4);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_set(input int size, input int flavour);
    for (int i = 0; i < size; i++) begin
      // Mixed sets draw each value's flavour afresh.
      send_sample(pick_value(flavour == 3 ? $urandom_range(0, 2) : flavour), i == size - 1);
    end
  endtask

  initial begin : stimulus
    int rank_plan [PHASES];
    int odds_plan [PHASES];
    int cur_rank;
    int sent;
    int size;
    int pick;

    // Every input of the block is known from time zero.
    samp_if.valid        = 1'b0;
    samp_if.sample_value = '0;
    samp_if.end_of_set   = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.rank_k        = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The rank is still at its reset value of one here, so the
    // first set checks the largest value at both ends of the signed range.
    idle_odds = 5;
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    // A one-item set holding the most negative value: a valid answer that
    // carries the same value as an invalid one.
    send_sample(32'h8000_0000, 1'b1);

    // Rank zero is never valid.
    settle();
    write_rank(RANK_W'(0));
    send_sample(32'd5, 1'b0);
    send_sample(32'd7, 1'b1);

    // Rank beyond the size of the set.
    settle();
    write_rank(RANK_W'(3));
    send_sample(32'd2, 1'b1);

    // Full kept set: sixteen rising values fill every cell, then a last one
    // just above the smallest pushes it out, so the sixteenth largest changes.
    settle();
    write_rank(RANK_W'(K_MAX));
    for (int i = 0; i < K_MAX; i++) send_sample(DATA_WIDTH'(i - 8), 1'b0);
    send_sample(32'hFFFF_FFF9, 1'b1);

    // Random part. Each phase runs under its own rank and idling rate; the
    // ranks cover zero, one, the deepest cell, one past it and the register's
    // top value. Phases six and seven draw the rank at random. The last phase
    // runs with no idling at all.
    rank_plan = '{16, 0, 1, 31, 17, 2, 0, 0, 15, 16};
    odds_plan = '{4, 8, 0, 3, 12, 0, 6, 2, 10, 0};
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      idle_odds = odds_plan[phase];
      calm      = (phase == PHASES - 1);
      cur_rank  = (phase == 6 || phase == 7) ? $urandom_range(0, 31) : rank_plan[phase];
      // In one phase the receiver holds off for a long stretch while samples
      // keep coming, so the output register and skid stage fill and the
      // sample channel has to stall.
      if (phase == 2) hold_asks++;
      write_rank(RANK_W'(cur_rank));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short sets, many sized close to the rank so that both sides
        // of the set-size boundary are hit, some that overfill the cells and
        // a few long enough to saturate the item count.
        pick = $urandom_range(0, 9);
        if (pick < 5)
          size = $urandom_range(1, 12);
        else if (pick < 7)
          size = cur_rank + $urandom_range(0, 4) - 2;
        else if (pick < 9)
          size = $urandom_range(13, 24);
        else
          size = $urandom_range(30, 40);
        if (size < 1) size = 1;
        send_set(size, $urandom_range(0, 3));
        sent += size;
      end
    end

    // Drain: all owed answers back, then a short margin for any stray beat.
    samp_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
